// ----- design/gpu_pkg.sv -----
`default_nettype none
package gpu_pkg;

    localparam int GRID_DEF   = 63;
    localparam int LEVELS_DEF = 16;

    // Store geometry and field widths fixed by the item format
    localparam int PT_DEPTH  = 64;
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 32;
    localparam int SPEC_W    = 16;
    localparam int WGT_W     = 17;
    localparam int PUR_W     = 17;
    localparam int NCN_W     = 4;
    localparam int TC_W      = 16;
    localparam int LVL_CNT_W = 5;
    localparam int DEN_W     = 24;
    localparam int NM_W      = 31;
    localparam int UN_W      = 48;
    localparam int SUM_W     = 54;
    localparam int S2_W      = 55;
    localparam int DIV_W     = 56;
    localparam int QUO_W     = 32;
    localparam int CNT_W     = 6;
    localparam int ACC_W     = 37;

    localparam logic [PUR_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [1:0] FUNC_LOAD_GRID  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_LEVEL = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE    = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_POINT,
        ST_LEVEL,
        ST_NM,
        ST_CHECK,
        ST_DIV,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_TERM,
        ST_PRIOR,
        ST_UNORM,
        ST_STORE,
        ST_NORM,
        ST_NCHECK,
        ST_ERR,
        ST_RD,
        ST_NUM,
        ST_OVF,
        ST_DIV2,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] rem_init;
        logic [DIV_W-1:0] den;
        logic [QUO_W-1:0] bits;
        logic [CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- design/gpu_req_if.sv -----
`default_nettype none
interface gpu_req_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        func;
    logic [gpu_pkg::IDX_W-1:0]         entry_index;
    logic [gpu_pkg::VAL_W-1:0]         emit_value;
    logic [gpu_pkg::VAL_W-1:0]         prior_value;
    logic [gpu_pkg::SPEC_W-1:0]        spectrum_value;
    logic [gpu_pkg::WGT_W-1:0]         weight_value;
    logic [gpu_pkg::PUR_W-1:0]         purity;
    logic [gpu_pkg::NCN_W-1:0]         normal_copy_count;
    logic [gpu_pkg::TC_W-1:0]          total_copy;

    modport source (output valid, func, entry_index, emit_value, prior_value,
                    spectrum_value, weight_value, purity, normal_copy_count,
                    total_copy, input ready);
    modport sink (input valid, func, entry_index, emit_value, prior_value,
                  spectrum_value, weight_value, purity, normal_copy_count,
                  total_copy, output ready);
endinterface
`default_nettype wire

// ----- design/gpu_rsp_if.sv -----
`default_nettype none
interface gpu_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [gpu_pkg::IDX_W-1:0] grid_index;
    logic [gpu_pkg::VAL_W-1:0] posterior_value;
    logic [gpu_pkg::IDX_W-1:0] peak_index;
    logic                      error;
    logic                      last;

    modport source (output valid, grid_index, posterior_value, peak_index, error, last,
                    input ready);
    modport sink (input valid, grid_index, posterior_value, peak_index, error, last,
                  output ready);
endinterface
`default_nettype wire

// ----- design/gpu_cfg_if.sv -----
`default_nettype none
interface gpu_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gpu_pkg::LVL_CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- design/gpu_ram.sv -----
`default_nettype none
module gpu_ram #(
    parameter int W = 32,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem_reg [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- design/gpu_div.sv -----
`default_nettype none
module gpu_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gpu_pkg::div_req_t req,
    output gpu_pkg::div_rsp_t      rsp
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [gpu_pkg::CNT_W-1:0]     cnt_reg;
    logic [gpu_pkg::DIV_W-1:0]     r_reg;
    logic [gpu_pkg::DIV_W-1:0]     d_reg;
    logic [gpu_pkg::QUO_W-1:0]     bits_reg;
    logic [gpu_pkg::QUO_W-1:0]     q_reg;
    logic [gpu_pkg::DIV_W-1:0]     r_shift;
    logic                          take;

    // Shift in one dividend bit; the partial remainder stays below the divisor
    assign r_shift = {r_reg[gpu_pkg::DIV_W-2:0], bits_reg[gpu_pkg::QUO_W-1]};
    assign take    = (r_shift >= d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == gpu_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            r_reg    <= req.rem_init;
            d_reg    <= req.den;
            bits_reg <= req.bits;
            cnt_reg  <= req.count;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            r_reg    <= take ? (r_shift - d_reg) : r_shift;
            q_reg    <= {q_reg[gpu_pkg::QUO_W-2:0], take};
            bits_reg <= {bits_reg[gpu_pkg::QUO_W-2:0], 1'b0};
            cnt_reg  <= cnt_reg - gpu_pkg::CNT_W'(1);
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule
`default_nettype wire

// ----- design/gpu_seq.sv -----
`default_nettype none
module gpu_seq #(
    parameter int GRID   = gpu_pkg::GRID_DEF,
    parameter int LEVELS = gpu_pkg::LEVELS_DEF,
    localparam int LAW = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    gpu_req_if.sink                            req,
    gpu_rsp_if.source                          rsp,
    input  wire logic [gpu_pkg::LVL_CNT_W-1:0] levels
);

    localparam logic [gpu_pkg::IDX_W-1:0]     GRID_IDX = gpu_pkg::IDX_W'(GRID);
    localparam logic [6:0]                    GRID2    = 7'(2 * GRID);
    localparam logic [gpu_pkg::LVL_CNT_W-1:0] LVL_MAX  = gpu_pkg::LVL_CNT_W'(LEVELS);

    gpu_pkg::seq_state_t state_reg, state_next;

    // Run parameters
    logic [gpu_pkg::DEN_W-1:0]     den_reg;
    logic [16:0]                   omp_reg;
    logic [gpu_pkg::NCN_W-1:0]     ncn_reg;
    logic [gpu_pkg::LVL_CNT_W-1:0] nlev_reg;
    logic [20:0]                   a_reg;
    logic [29:0]                   gden_reg;

    // Point and level loop
    logic [gpu_pkg::IDX_W-1:0]     i_reg;
    logic [gpu_pkg::LVL_CNT_W-1:0] j_reg;
    logic [26:0]                   base_reg;
    logic [gpu_pkg::NM_W-1:0]      nm_reg;
    logic [gpu_pkg::WGT_W-1:0]     w_reg;
    logic [gpu_pkg::IDX_W-1:0]     i1_reg;
    logic [15:0]                   nu_reg;
    logic [48:0]                   p1_reg;
    logic [31:0]                   ip_reg;
    logic [gpu_pkg::ACC_W-1:0]     acc_reg;
    logic [gpu_pkg::UN_W-1:0]      u_reg;
    logic [gpu_pkg::SUM_W-1:0]     sum_reg;
    logic [gpu_pkg::UN_W-1:0]      u0_reg;
    logic [gpu_pkg::UN_W-1:0]      ug_reg;
    logic [gpu_pkg::UN_W-1:0]      best_reg;
    logic [gpu_pkg::IDX_W-1:0]     peak_reg;
    logic [gpu_pkg::S2_W-1:0]      s2_reg;
    logic [gpu_pkg::S2_W-1:0]      num_reg;
    logic [gpu_pkg::VAL_W-1:0]     post_reg;

    // Memory ports
    logic                          pt_we;
    logic                          lv_we;
    logic                          un_we;
    logic [gpu_pkg::IDX_W-1:0]     emis_raddr;
    logic [gpu_pkg::VAL_W-1:0]     emis_rdata;
    logic [gpu_pkg::VAL_W-1:0]     prior_rdata;
    logic [gpu_pkg::SPEC_W-1:0]    spec_rdata;
    logic [gpu_pkg::WGT_W-1:0]     wgt_rdata;
    logic [gpu_pkg::UN_W-1:0]      un_rdata;

    gpu_pkg::div_req_t             div_req;
    gpu_pkg::div_rsp_t             div_rsp;

    logic                          accept;
    logic                          skip;
    logic                          ovf;
    logic [gpu_pkg::IDX_W-1:0]     i2;
    logic [31:0]                   s_sat;
    logic [48:0]                   interp_sum;
    logic [48:0]                   term_prod;
    logic [63:0]                   u_prod;
    logic [29:0]                   spec_term;

    assign accept    = req.valid && req.ready;
    assign skip      = nm_reg > gpu_pkg::NM_W'(gden_reg);
    assign ovf       = {16'b0, num_reg} >= {s2_reg, 16'b0};
    assign i2        = (i1_reg < GRID_IDX) ? i1_reg + gpu_pkg::IDX_W'(1) : i1_reg;
    assign s_sat     = (acc_reg > gpu_pkg::ACC_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                  : acc_reg[31:0];
    assign interp_sum = p1_reg + 49'({17'b0, nu_reg} * emis_rdata);
    assign term_prod  = 49'(ip_reg * w_reg);
    assign u_prod     = s_sat * prior_rdata;
    assign spec_term  = {30'(spec_rdata * 6'(GRID))} << 8;

    gpu_ram #(.W(gpu_pkg::VAL_W), .D(gpu_pkg::PT_DEPTH)) u_emis_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (req.entry_index),
        .wdata (req.emit_value),
        .raddr (emis_raddr),
        .rdata (emis_rdata)
    );

    gpu_ram #(.W(gpu_pkg::VAL_W), .D(gpu_pkg::PT_DEPTH)) u_prior_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (req.entry_index),
        .wdata (req.prior_value),
        .raddr (i_reg),
        .rdata (prior_rdata)
    );

    gpu_ram #(.W(gpu_pkg::SPEC_W), .D(LEVELS)) u_spec_ram (
        .clk   (clk),
        .we    (lv_we),
        .waddr (req.entry_index[LAW-1:0]),
        .wdata (req.spectrum_value),
        .raddr (j_reg[LAW-1:0]),
        .rdata (spec_rdata)
    );

    gpu_ram #(.W(gpu_pkg::WGT_W), .D(LEVELS)) u_wgt_ram (
        .clk   (clk),
        .we    (lv_we),
        .waddr (req.entry_index[LAW-1:0]),
        .wdata (req.weight_value),
        .raddr (j_reg[LAW-1:0]),
        .rdata (wgt_rdata)
    );

    gpu_ram #(.W(gpu_pkg::UN_W), .D(gpu_pkg::PT_DEPTH)) u_un_ram (
        .clk   (clk),
        .we    (un_we),
        .waddr (i_reg),
        .wdata (u_reg),
        .raddr (i_reg),
        .rdata (un_rdata)
    );

    gpu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gpu_pkg::ST_IDLE:
                if (accept && req.func == gpu_pkg::FUNC_COMPUTE)
                    state_next = gpu_pkg::ST_SETUP;
            gpu_pkg::ST_SETUP:  state_next = gpu_pkg::ST_POINT;
            gpu_pkg::ST_POINT:  state_next = gpu_pkg::ST_LEVEL;
            gpu_pkg::ST_LEVEL:
                state_next = (j_reg == nlev_reg) ? gpu_pkg::ST_PRIOR : gpu_pkg::ST_NM;
            gpu_pkg::ST_NM:     state_next = gpu_pkg::ST_CHECK;
            gpu_pkg::ST_CHECK:
                state_next = skip ? gpu_pkg::ST_LEVEL : gpu_pkg::ST_DIV;
            gpu_pkg::ST_DIV:
                if (div_rsp.done)
                    state_next = gpu_pkg::ST_F1;
            gpu_pkg::ST_F1:     state_next = gpu_pkg::ST_F2;
            gpu_pkg::ST_F2:     state_next = gpu_pkg::ST_F3;
            gpu_pkg::ST_F3:     state_next = gpu_pkg::ST_TERM;
            gpu_pkg::ST_TERM:   state_next = gpu_pkg::ST_LEVEL;
            gpu_pkg::ST_PRIOR:  state_next = gpu_pkg::ST_UNORM;
            gpu_pkg::ST_UNORM:  state_next = gpu_pkg::ST_STORE;
            gpu_pkg::ST_STORE:
                state_next = (i_reg == GRID_IDX) ? gpu_pkg::ST_NORM : gpu_pkg::ST_POINT;
            gpu_pkg::ST_NORM:   state_next = gpu_pkg::ST_NCHECK;
            gpu_pkg::ST_NCHECK:
                state_next = (s2_reg == '0) ? gpu_pkg::ST_ERR : gpu_pkg::ST_RD;
            gpu_pkg::ST_ERR:
                if (rsp.ready)
                    state_next = gpu_pkg::ST_IDLE;
            gpu_pkg::ST_RD:     state_next = gpu_pkg::ST_NUM;
            gpu_pkg::ST_NUM:    state_next = gpu_pkg::ST_OVF;
            gpu_pkg::ST_OVF:
                state_next = ovf ? gpu_pkg::ST_EMIT : gpu_pkg::ST_DIV2;
            gpu_pkg::ST_DIV2:
                if (div_rsp.done)
                    state_next = gpu_pkg::ST_EMIT;
            gpu_pkg::ST_EMIT:
                if (rsp.ready)
                    state_next = (i_reg == GRID_IDX) ? gpu_pkg::ST_IDLE : gpu_pkg::ST_RD;
            default:            state_next = gpu_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready  = (state_reg == gpu_pkg::ST_IDLE);
        pt_we      = accept && req.func == gpu_pkg::FUNC_LOAD_GRID;
        lv_we      = accept && req.func == gpu_pkg::FUNC_LOAD_LEVEL
                     && {1'b0, req.entry_index} < 7'(LEVELS);
        un_we      = (state_reg == gpu_pkg::ST_STORE);
        emis_raddr = (state_reg == gpu_pkg::ST_F2) ? i2 : i1_reg;

        div_req          = '0;
        div_req.start    = (state_reg == gpu_pkg::ST_CHECK && !skip)
                           || (state_reg == gpu_pkg::ST_OVF && !ovf);
        if (state_reg == gpu_pkg::ST_OVF)
        begin
            div_req.rem_init = gpu_pkg::DIV_W'(num_reg >> 16);
            div_req.den      = gpu_pkg::DIV_W'(s2_reg);
            div_req.bits     = {num_reg[15:0], 16'b0};
            div_req.count    = gpu_pkg::CNT_W'(32);
        end
        else
        begin
            div_req.rem_init = gpu_pkg::DIV_W'(nm_reg >> 6);
            div_req.den      = gpu_pkg::DIV_W'(den_reg);
            div_req.bits     = {nm_reg[5:0], 26'b0};
            div_req.count    = gpu_pkg::CNT_W'(22);
        end

        rsp.valid           = (state_reg == gpu_pkg::ST_EMIT)
                              || (state_reg == gpu_pkg::ST_ERR);
        rsp.error           = (state_reg == gpu_pkg::ST_ERR);
        rsp.last            = rsp.error || (i_reg == GRID_IDX);
        rsp.grid_index      = rsp.error ? '0 : i_reg;
        rsp.posterior_value = rsp.error ? '0 : post_reg;
        rsp.peak_index      = (!rsp.error && i_reg == GRID_IDX) ? peak_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            gpu_pkg::ST_IDLE:
            begin
                if (accept && req.func == gpu_pkg::FUNC_COMPUTE)
                begin
                    omp_reg  <= (req.purity >= gpu_pkg::ONE_Q16) ? '0
                                : gpu_pkg::ONE_Q16 - req.purity;
                    ncn_reg  <= req.normal_copy_count;
                    den_reg  <= {((req.total_copy == '0) ? 16'd1 : req.total_copy), 8'b0};
                    nlev_reg <= (levels > LVL_MAX) ? LVL_MAX : levels;
                    i_reg    <= '0;
                    sum_reg  <= '0;
                end
            end
            gpu_pkg::ST_SETUP:
            begin
                a_reg    <= 21'(omp_reg * ncn_reg);
                gden_reg <= 30'(den_reg * 6'(GRID));
            end
            gpu_pkg::ST_POINT:
            begin
                base_reg <= 27'(i_reg * a_reg);
                acc_reg  <= '0;
                j_reg    <= '0;
            end
            gpu_pkg::ST_NM:
            begin
                nm_reg <= gpu_pkg::NM_W'(base_reg) + gpu_pkg::NM_W'(spec_term);
                w_reg  <= wgt_rdata;
            end
            gpu_pkg::ST_CHECK:
            begin
                if (skip)
                    j_reg <= j_reg + gpu_pkg::LVL_CNT_W'(1);
            end
            gpu_pkg::ST_DIV:
            begin
                i1_reg <= div_rsp.quo[21:16];
                nu_reg <= div_rsp.quo[15:0];
            end
            gpu_pkg::ST_F2:
                p1_reg <= 49'((17'h10000 - {1'b0, nu_reg}) * emis_rdata);
            gpu_pkg::ST_F3:
                ip_reg <= interp_sum[47:16];
            gpu_pkg::ST_TERM:
            begin
                acc_reg <= acc_reg + gpu_pkg::ACC_W'(term_prod[48:16]);
                j_reg   <= j_reg + gpu_pkg::LVL_CNT_W'(1);
            end
            gpu_pkg::ST_UNORM:
                u_reg <= u_prod[63:16];
            gpu_pkg::ST_STORE:
            begin
                sum_reg <= sum_reg + gpu_pkg::SUM_W'(u_reg);
                if (i_reg == '0 || u_reg > best_reg)
                begin
                    best_reg <= u_reg;
                    peak_reg <= i_reg;
                end
                if (i_reg == '0)
                    u0_reg <= u_reg;
                if (i_reg == GRID_IDX)
                    ug_reg <= u_reg;
                else
                    i_reg <= i_reg + gpu_pkg::IDX_W'(1);
            end
            gpu_pkg::ST_NORM:
                s2_reg <= {sum_reg, 1'b0} - gpu_pkg::S2_W'(u0_reg) - gpu_pkg::S2_W'(ug_reg);
            gpu_pkg::ST_NCHECK:
                i_reg <= '0;
            gpu_pkg::ST_NUM:
                num_reg <= gpu_pkg::S2_W'(un_rdata * GRID2);
            gpu_pkg::ST_OVF:
            begin
                if (ovf)
                    post_reg <= 32'hFFFF_FFFF;
            end
            gpu_pkg::ST_DIV2:
            begin
                if (div_rsp.done)
                    post_reg <= div_rsp.quo;
            end
            gpu_pkg::ST_EMIT:
            begin
                if (rsp.ready && i_reg != GRID_IDX)
                    i_reg <= i_reg + gpu_pkg::IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/grid_posterior_update_top.sv -----
// grid_posterior_update_top: Bayesian posterior over a uniform frequency grid.
//
// Channels (valid/ready, a transaction moves when both are high):
//   req  - input items. func selects a grid point load (emission and prior),
//          a level load (spectrum and weight) or a compute run.
//   rsp  - results. A compute run gives GRID+1 results, one per grid point,
//          with last and the peak index on the final one, or a single result
//          with error and last set when the normalization sum is zero.
//   cfg  - write of levels_in_use; take it only while the block is idle.
// Flow: loads are taken back to back while the block is idle. A compute
//   run holds req.ready low through the accumulation over every grid point
//   and every level in use (a level above the unit interval skips the
//   division), paced by the 22-step serial divider and the emission memory
//   read twice per level; then through each result, paced by the 32-step divider unless the result saturates.
// Reset: clears the sequencer and sets levels_in_use to 16. Stores hold
//   garbage until loaded; no clearing pass runs.
// Stall: a result sits in the output register until rsp.ready; the run
//   holds there and accepts no new transaction meanwhile.
`default_nettype none
module grid_posterior_update_top #(
    parameter int GRID   = gpu_pkg::GRID_DEF,
    parameter int LEVELS = gpu_pkg::LEVELS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gpu_req_if.sink   req,
    gpu_rsp_if.source rsp,
    gpu_cfg_if.sink   cfg
);

    logic [gpu_pkg::LVL_CNT_W-1:0] levels_reg;

    // Configuration is always taken; the caller must write only when idle, the block does not enforce it
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= gpu_pkg::LVL_CNT_W'(16);
        end
        else if (cfg.valid && cfg.ready)
        begin
            levels_reg <= cfg.data;
        end
    end

    // Sequencer owns the stores, the divider and the output register
    gpu_seq #(
        .GRID   (GRID),
        .LEVELS (LEVELS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .levels (levels_reg)
    );

    // Hold off input while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("input accepted while result pending");

    // Error result stands alone and carries no posterior
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.error) |-> (rsp.last && rsp.posterior_value == '0))
        else $error("error result malformed");

    // Peak index only on the final result
    a_peak_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (rsp.peak_index == '0))
        else $error("peak index on non-final result");

    // Final normal result is the last grid point
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.last && !rsp.error) |-> (rsp.grid_index == gpu_pkg::IDX_W'(GRID)))
        else $error("last flag on wrong grid point");

endmodule
`default_nettype wire
